>>> rtl/qlu_pkg.sv
// Shared types and constants for the quoted literal unquoter.
// No dependencies; compiled first.
package qlu_pkg;

	// Result codes
	typedef enum logic [1:0] {
		KIND_CONTENT = 2'd0,
		KIND_END     = 2'd1,
		KIND_UNTERM  = 2'd2
	} kind_t;

	localparam int OUT_CNT_W  = 16;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register word indexes
	localparam logic REG_TASM_COMPAT = 1'b0;

	localparam logic [7:0] TOP_BIT = 8'h80;

endpackage

>>> rtl/qlu_if.sv
// Valid/ready channel interfaces for source bytes and result items.
// Depends on nothing; compiled after qlu_pkg.
interface qlu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] src_byte;
	logic       start_req;

	modport source(output valid, src_byte, start_req, input ready);
	modport sink(input valid, src_byte, start_req, output ready);
endinterface

interface qlu_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  content_byte;
	logic [15:0] consumed_len;
	logic [15:0] char_count;

	modport source(output valid, kind, content_byte, consumed_len, char_count, input ready);
	modport sink(input valid, kind, content_byte, consumed_len, char_count, output ready);
endinterface

>>> rtl/qlu_apb.sv
// APB-style configuration register file: holds the compatibility flag.
// Depends on qlu_pkg.
module qlu_apb (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [qlu_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [qlu_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [qlu_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output logic                             tasm_compat
);
	import qlu_pkg::*;

	logic tasm_compat_q;
	logic word_idx;
	logic wr_en;

	assign word_idx = paddr[APB_ADDR_W-1];
	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tasm_compat_q <= 1'b0;
		end else if (wr_en && word_idx == REG_TASM_COMPAT) begin
			tasm_compat_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (word_idx == REG_TASM_COMPAT) begin
			prdata[0] = tasm_compat_q;
		end
	end

	assign tasm_compat = tasm_compat_q;

endmodule

>>> rtl/qlu_core.sv
// Unquoting datapath: input register, literal state, one-step update, result register.
// Depends on qlu_pkg and qlu_if.
module qlu_core #(
	parameter int COUNT_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tasm_compat,
	qlu_in_if.sink    src,
	qlu_out_if.source res
);
	import qlu_pkg::*;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// Literal state
	logic [7:0]            quote_q;
	logic                  active_q;
	logic                  pending_q;
	logic [2:0]            cont_q;
	logic [COUNT_BITS-1:0] cons_q;
	logic [COUNT_BITS-1:0] chars_q;

	// Result register
	logic                  res_valid_q;
	kind_t                 kind_q;
	logic [7:0]            byte_q;
	logic [COUNT_BITS-1:0] ocons_q;
	logic [COUNT_BITS-1:0] ochars_q;

	// Next-state
	logic [7:0]            n_quote;
	logic                  n_active;
	logic                  n_pending;
	logic [2:0]            n_cont;
	logic [COUNT_BITS-1:0] n_cons;
	logic [COUNT_BITS-1:0] n_chars;
	logic                  emit;
	kind_t                 o_kind;
	logic [7:0]            o_byte;
	logic [COUNT_BITS-1:0] o_cons;
	logic [COUNT_BITS-1:0] o_chars;
	logic [COUNT_BITS-1:0] cons_inc;
	logic [COUNT_BITS-1:0] chars_inc;

	logic advance;
	logic fire;

	function automatic logic [2:0] extra_bytes(input logic [7:0] b);
		priority if (b < 8'h80) return 3'd0;
		else if (b < 8'hE0)     return 3'd1;
		else if (b < 8'hF0)     return 3'd2;
		else if (b < 8'hF8)     return 3'd3;
		else if (b < 8'hFC)     return 3'd4;
		else                    return 3'd5;
	endfunction

	assign advance   = !res_valid_q || res.ready;
	assign fire      = valid_s1 && advance;
	assign src.ready = !valid_s1 || advance;

	assign cons_inc  = (cons_q == '1) ? cons_q : cons_q + 1'b1;
	assign chars_inc = (chars_q == '1) ? chars_q : chars_q + 1'b1;

	always_comb begin
		n_quote   = quote_q;
		n_active  = active_q;
		n_pending = pending_q;
		n_cont    = cont_q;
		n_cons    = cons_q;
		n_chars   = chars_q;
		emit      = 1'b0;
		o_kind    = KIND_CONTENT;
		o_byte    = '0;
		o_cons    = cons_q;
		o_chars   = chars_q;
		if (start_s1) begin
			// pending quote: this byte is the lookahead; otherwise old literal abandoned
			emit      = active_q;
			o_kind    = pending_q ? KIND_END : KIND_UNTERM;
			n_quote   = byte_s1;
			n_active  = 1'b1;
			n_pending = 1'b0;
			n_cont    = '0;
			n_cons    = COUNT_BITS'(1);
			n_chars   = '0;
		end else if (active_q) begin
			if (pending_q) begin
				n_pending = 1'b0;
				emit      = 1'b1;
				if (byte_s1 == quote_q && !tasm_compat) begin
					n_cons  = cons_inc;
					n_chars = chars_inc;
					o_cons  = cons_inc;
					o_chars = chars_inc;
					o_byte  = byte_s1;
				end else begin
					n_active = 1'b0;
					o_kind   = KIND_END;
				end
			end else if (cont_q != 3'd0) begin
				n_cont = cont_q - 3'd1;
				n_cons = cons_inc;
				o_cons = cons_inc;
				emit   = 1'b1;
				o_byte = byte_s1;
			end else if (byte_s1 == 8'd0) begin
				n_active = 1'b0;
				emit     = 1'b1;
				o_kind   = KIND_UNTERM;
			end else if (byte_s1 == quote_q) begin
				n_cons = cons_inc;
				if (tasm_compat) begin
					n_active = 1'b0;
					emit     = 1'b1;
					o_kind   = KIND_END;
					o_cons   = cons_inc;
				end else begin
					n_pending = 1'b1;
				end
			end else begin
				n_cons  = cons_inc;
				n_chars = chars_inc;
				o_cons  = cons_inc;
				o_chars = chars_inc;
				emit    = 1'b1;
				o_byte  = byte_s1;
				if ((byte_s1 & TOP_BIT) != 8'd0) begin
					n_cont = extra_bytes(byte_s1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.ready && src.valid) begin
			byte_s1  <= src.src_byte;
			start_s1 <= src.start_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q   <= '0;
			active_q  <= 1'b0;
			pending_q <= 1'b0;
			cont_q    <= '0;
			cons_q    <= '0;
			chars_q   <= '0;
		end else if (fire) begin
			quote_q   <= n_quote;
			active_q  <= n_active;
			pending_q <= n_pending;
			cont_q    <= n_cont;
			cons_q    <= n_cons;
			chars_q   <= n_chars;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_q   <= o_kind;
			byte_q   <= o_byte;
			ocons_q  <= o_cons;
			ochars_q <= o_chars;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.kind         = kind_q;
	assign res.content_byte = byte_q;

	// Counts wider than the port are reported saturated at the port width; narrower ones are zero-extended
	generate
		if (COUNT_BITS > OUT_CNT_W) begin : g_wide
			assign res.consumed_len = (|ocons_q[COUNT_BITS-1:OUT_CNT_W]) ? '1
				: ocons_q[OUT_CNT_W-1:0];
			assign res.char_count   = (|ochars_q[COUNT_BITS-1:OUT_CNT_W]) ? '1
				: ochars_q[OUT_CNT_W-1:0];
		end else if (COUNT_BITS == OUT_CNT_W) begin : g_equal
			assign res.consumed_len = ocons_q;
			assign res.char_count   = ochars_q;
		end else begin : g_narrow
			assign res.consumed_len = {{(OUT_CNT_W-COUNT_BITS){1'b0}}, ocons_q};
			assign res.char_count   = {{(OUT_CNT_W-COUNT_BITS){1'b0}}, ochars_q};
		end
	endgenerate

	a_pending_active: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> active_q)
		else $error("pending quote outside a literal");

	a_cont_active: assert property (@(posedge clk) disable iff (!arst_n)
		(cont_q != 3'd0) |-> (active_q && !pending_q))
		else $error("continuation count outside plain literal body");

	a_start_init: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && start_s1) |=> (active_q && cons_q == COUNT_BITS'(1) && chars_q == '0))
		else $error("literal start did not initialise state");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !start_s1 && !active_q) |=> !res_valid_q)
		else $error("result produced for an idle byte");

endmodule

>>> rtl/quoted_literal_unquoter.sv
// Top level of the quoted literal unquoter: configuration port and datapath.
// Depends on qlu_pkg, qlu_if, qlu_apb and qlu_core.
//
//   channel | dir | handshake          | carries
//   src     | in  | valid/ready        | src_byte, start_req
//   res     | out | valid/ready        | kind, content_byte, consumed_len, char_count
//   apb     | in  | psel/penable       | tasm_compat at byte address 0
//
// One source byte per cycle while the result is not stalled; a transaction's result passes through
// the input register, then the result register, throughput set by the single-step state update.
// arst_n clears the literal state, valid flags and the configuration flag.
// A stalled result holds in the result register; src.ready drops only while both the
// input and result registers are full and res.ready is low.
module quoted_literal_unquoter #(
	parameter int COUNT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	qlu_in_if.sink                           src,
	qlu_out_if.source                        res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [qlu_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [qlu_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [qlu_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import qlu_pkg::*;

	logic tasm_compat;

	qlu_apb u_apb (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.tasm_compat (tasm_compat)
	);

	qlu_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.tasm_compat (tasm_compat),
		.src         (src),
		.res         (res)
	);

endmodule
